>>> rtl/fimag_pkg.sv
// fimag_pkg: shared types, constants and binary32 arithmetic helpers
// for the fast inverse magnitude pipeline; no dependencies
package fimag_pkg;

  localparam logic [31:0] MAGIC        = 32'h5F3759DF;
  localparam logic [31:0] HALF         = 32'h3F000000;
  localparam logic [31:0] ONE_AND_HALF = 32'h3FC00000;
  localparam logic [31:0] QNAN         = 32'h7FC00000;
  localparam logic [30:0] INF_MAG      = 31'h7F800000;
  localparam int          LATENCY      = 22;

  // result of the first half of an operation: a special value or an
  // unrounded significand with its exponent
  typedef struct packed {
    logic              spec;
    logic [31:0]       sval;
    logic              sign;
    logic signed [10:0] ex;
    logic [55:0]       sig;
  } inter_t;

  // stage handshake shared with the newton block
  typedef struct packed {
    logic en;
    logic vld;
  } ctl_t;

  function automatic logic is_nan(logic [31:0] a);
    return a[30:0] > INF_MAG;
  endfunction

  function automatic logic is_inf(logic [31:0] a);
    return a[30:0] == INF_MAG;
  endfunction

  function automatic logic is_zero(logic [31:0] a);
    return a[30:0] == 31'd0;
  endfunction

  function automatic logic [23:0] mant(logic [31:0] a);
    return (a[30:23] == 8'd0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
  endfunction

  function automatic logic signed [10:0] expo(logic [31:0] a);
    return (a[30:23] == 8'd0) ? -11'sd149 : ($signed({3'b0, a[30:23]}) - 11'sd150);
  endfunction

  // multiply, first half: specials and the full product
  function automatic inter_t mul_pre(logic [31:0] a, logic [31:0] b);
    inter_t r;
    logic   s;
    s      = a[31] ^ b[31];
    r.spec = 1'b1;
    r.sval = {s, 31'd0};
    r.sign = s;
    r.ex   = expo(a) + expo(b);
    r.sig  = {8'd0, 48'(mant(a)) * 48'(mant(b))};
    if (is_nan(a) || is_nan(b)) begin
      r.sval = QNAN;
    end else if (is_inf(a) || is_inf(b)) begin
      r.sval = (is_zero(a) || is_zero(b)) ? QNAN : {s, INF_MAG};
    end else if (!(is_zero(a) || is_zero(b))) begin
      r.spec = 1'b0;
    end
    return r;
  endfunction

  // add, first half: specials, alignment with sticky bit and the sum
  function automatic inter_t add_pre(logic [31:0] a, logic [31:0] b);
    inter_t             r;
    logic [23:0]        ma, mb;
    logic signed [10:0] ea, eb, d;
    logic               sa, sb;
    logic [53:0]        va, vb, full;
    r.spec = 1'b1;
    r.sval = QNAN;
    r.sign = 1'b0;
    r.ex   = 11'sd0;
    r.sig  = 56'd0;
    ma = mant(a); ea = expo(a); sa = a[31];
    mb = mant(b); eb = expo(b); sb = b[31];
    if (eb > ea) begin
      ma = mant(b); ea = expo(b); sa = b[31];
      mb = mant(a); eb = expo(a); sb = a[31];
    end
    d    = ea - eb;
    va   = {ma, 30'd0};
    full = {mb, 30'd0};
    if (d >= 11'sd62) begin
      vb = {53'd0, |mb};
    end else begin
      vb = full >> d[5:0];
      if ((vb << d[5:0]) != full) vb[0] = 1'b1;
    end
    r.ex = ea - 11'sd30;
    if (is_nan(a) || is_nan(b)) begin
      r.sval = QNAN;
    end else if (is_inf(a) && is_inf(b)) begin
      r.sval = (a[31] == b[31]) ? a : QNAN;
    end else if (is_inf(a)) begin
      r.sval = a;
    end else if (is_inf(b)) begin
      r.sval = b;
    end else if (is_zero(a) && is_zero(b)) begin
      r.sval = {a[31] & b[31], 31'd0};
    end else if (is_zero(a)) begin
      r.sval = b;
    end else if (is_zero(b)) begin
      r.sval = a;
    end else if (sa == sb) begin
      r.spec = 1'b0;
      r.sign = sa;
      r.sig  = {1'b0, 55'(va) + 55'(vb)};
    end else if (va == vb) begin
      r.sval = 32'd0;
    end else if (va > vb) begin
      r.spec = 1'b0;
      r.sign = sa;
      r.sig  = {2'b0, va - vb};
    end else begin
      r.spec = 1'b0;
      r.sign = sb;
      r.sig  = {2'b0, vb - va};
    end
    return r;
  endfunction

  // second half: normalize, round to nearest even, detect overflow
  function automatic logic [31:0] finish(inter_t r);
    logic [5:0]         p;
    logic signed [12:0] sh, lim, nsh, tmp;
    logic [63:0]        sig64, q, rem, half, mask;
    logic signed [49:0] t;
    p = 6'd0;
    for (int i = 0; i < 56; i++) begin
      if (r.sig[i]) p = 6'(i);
    end
    sh  = $signed({7'b0, p}) - 13'sd23;
    lim = -13'sd149 - 13'(r.ex);
    if (lim > sh) sh = lim;
    nsh   = -sh;
    sig64 = 64'(r.sig);
    if (sh <= 13'sd0) begin
      q = sig64 << nsh[5:0];
    end else if (sh >= 13'sd57) begin
      q = 64'd0;
    end else begin
      mask = (64'd1 << sh[5:0]) - 64'd1;
      half = 64'd1 << (sh[5:0] - 6'd1);
      rem  = sig64 & mask;
      q    = sig64 >> sh[5:0];
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    end
    tmp = 13'(r.ex) + sh + 13'sd149;
    t   = $signed({27'(tmp), 23'b0}) + $signed({25'b0, q[24:0]});
    if (r.spec) return r.sval;
    if (t >= 50'sd2139095040) return {r.sign, INF_MAG};
    return {r.sign, t[30:0]};
  endfunction

endpackage

>>> rtl/fast_inverse_magnitude_2d_unit.sv
// channel | direction | ports                                  | beat when
// in      | input     | in_valid, in_stall, in_vec_x/y_bits    | in_valid & !in_stall
// out     | output    | out_valid, out_stall, out_inv_mag_bits | out_valid & !out_stall
//
// one beat per cycle while the output is not stalled; from input to output
// beat: six stages for squares, sum, halving and guess, eight per newton step
// every float operation takes two stages: product or aligned sum, then round
// a stall on a valid output beat freezes the whole pipeline; in_stall follows it
// synchronous active-low reset clears the valid bits only
//
// fast_inverse_magnitude_2d_unit: top level; depends on fimag_pkg, fimag_newton
module fast_inverse_magnitude_2d_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_vec_x_bits,
  input  logic [31:0] in_vec_y_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_inv_mag_bits
);

  logic              en;
  logic [5:0]        vld_r;
  fimag_pkg::inter_t xxi_r, yyi_r, mi_r, hi_r;
  logic [31:0]       xx_r, yy_r, m_r, g0_r, h_r, gs_r;
  fimag_pkg::ctl_t   ctl0, ctl1;
  logic              n0_vld;
  logic [31:0]       n0_h, n0_g, n1_h;

  // pipeline moves unless the output beat is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  // squares, sum, half and magic guess
  always_ff @(posedge clk) begin
    if (en) begin
      xxi_r <= fimag_pkg::mul_pre(in_vec_x_bits, in_vec_x_bits);
      yyi_r <= fimag_pkg::mul_pre(in_vec_y_bits, in_vec_y_bits);
      xx_r  <= fimag_pkg::finish(xxi_r);
      yy_r  <= fimag_pkg::finish(yyi_r);
      mi_r  <= fimag_pkg::add_pre(xx_r, yy_r);
      m_r   <= fimag_pkg::finish(mi_r);
      hi_r  <= fimag_pkg::mul_pre(m_r, fimag_pkg::HALF);
      g0_r  <= fimag_pkg::MAGIC - {m_r[31], m_r[31:1]};
      h_r   <= fimag_pkg::finish(hi_r);
      gs_r  <= g0_r;
    end
  end

  assign ctl0.en  = en;
  assign ctl0.vld = vld_r[5];
  assign ctl1.en  = en;
  assign ctl1.vld = n0_vld;

  fimag_newton u_step0 (
    .clk(clk), .rst_n(rst_n), .ctl(ctl0), .h_in(h_r), .g_in(gs_r),
    .vld_out(n0_vld), .h_out(n0_h), .g_out(n0_g)
  );

  fimag_newton u_step1 (
    .clk(clk), .rst_n(rst_n), .ctl(ctl1), .h_in(n0_h), .g_in(n0_g),
    .vld_out(out_valid), .h_out(n1_h), .g_out(out_inv_mag_bits)
  );

  // squares are never negative, nan included
  a_sq_sign: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[1] |-> !xx_r[31] && !yy_r[31])
    else $error("negative square");
  // zero or tiny sum halves to zero and leaves the bare magic guess
  a_zero_guess: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[5] && h_r == 32'd0 && n1_h == n1_h |-> gs_r == fimag_pkg::MAGIC)
    else $error("guess wrong for zero half");
  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("front valid bits moved while stalled");
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

>>> rtl/fimag_newton.sv
// fimag_newton: one newton step g * (1.5 - (h*g)*g), eight register stages
// depends on fimag_pkg
module fimag_newton (
  input  logic             clk,
  input  logic             rst_n,
  input  fimag_pkg::ctl_t  ctl,
  input  logic [31:0]      h_in,
  input  logic [31:0]      g_in,
  output logic             vld_out,
  output logic [31:0]      h_out,
  output logic [31:0]      g_out
);

  logic [7:0]        vld_r;
  logic [31:0]       h_r [8];
  logic [31:0]       g_r [6];
  fimag_pkg::inter_t a_r, b_r, c_r, d_r;
  logic [31:0]       p_r, t_r, s_r, gn_r;

  // valid bits advance with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.en) begin
      vld_r <= {vld_r[6:0], ctl.vld};
    end
  end

  // datapath: h*g, *g, 1.5 - t, g*s, each split in two halves
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      a_r  <= fimag_pkg::mul_pre(h_in, g_in);
      p_r  <= fimag_pkg::finish(a_r);
      b_r  <= fimag_pkg::mul_pre(p_r, g_r[1]);
      t_r  <= fimag_pkg::finish(b_r);
      c_r  <= fimag_pkg::add_pre(fimag_pkg::ONE_AND_HALF, {~t_r[31], t_r[30:0]});
      s_r  <= fimag_pkg::finish(c_r);
      d_r  <= fimag_pkg::mul_pre(g_r[5], s_r);
      gn_r <= fimag_pkg::finish(d_r);
      h_r[0] <= h_in;
      g_r[0] <= g_in;
      for (int i = 1; i < 8; i++) h_r[i] <= h_r[i-1];
      for (int i = 1; i < 6; i++) g_r[i] <= g_r[i-1];
    end
  end

  assign vld_out = vld_r[7];
  assign h_out   = h_r[7];
  assign g_out   = gn_r;

  // valid bits hold while stalled and clear on reset
  a_step_vld_move: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.en |=> $stable(vld_r))
    else $error("newton valid bits moved while stalled");
  a_step_fill: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.en && !vld_r[6] |=> !vld_out)
    else $error("newton output valid without a beat behind it");
  a_step_reset: assert property (@(posedge clk)
    !rst_n |=> vld_r == 8'd0)
    else $error("newton valid bits not cleared by reset");

endmodule

>>> dv/tb_fast_inverse_magnitude_2d_unit.sv
// tb_fast_inverse_magnitude_2d_unit: self-checking bench for the fast inverse
// magnitude pipeline; predicts each result with a bit-exact binary32 model
// depends on fast_inverse_magnitude_2d_unit and fimag_pkg constants
`timescale 1ns / 100ps

module tb_fast_inverse_magnitude_2d_unit;

  localparam int N_RANDOM   = 600;
  localparam int CALM_ITEMS = 100;
  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
  } vec_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_vec_x_bits;
  logic [31:0] in_vec_y_bits;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_inv_mag_bits;

  vec_t        vec_queue[$];
  logic [31:0] inv_mag_queue[$];
  int          n_fail;
  int          idle_cycles;
  bit          feed_done;
  bit          calm;
  bit          in_wait;
  int          in_gap;
  int          out_gap;

  fast_inverse_magnitude_2d_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_vec_x_bits    (in_vec_x_bits),
    .in_vec_y_bits    (in_vec_y_bits),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_inv_mag_bits (out_inv_mag_bits)
  );

  // binary32 helpers for the predictor
  function automatic bit fp_nan(logic [31:0] a);
    return a[30:0] > 31'h7F800000;
  endfunction

  function automatic bit fp_inf(logic [31:0] a);
    return a[30:0] == 31'h7F800000;
  endfunction

  function automatic bit fp_zero(logic [31:0] a);
    return a[30:0] == 31'd0;
  endfunction

  function automatic void fp_split(logic [31:0] a, output longint unsigned m,
                                   output int e);
    if (a[30:23] == 8'd0) begin
      m = a[22:0];
      e = -149;
    end else begin
      m = {1'b1, a[22:0]};
      e = int'(a[30:23]) - 150;
    end
  endfunction

  // normalize and round sig * 2^ex to nearest even
  function automatic logic [31:0] fp_round(logic sgn, int ex, longint unsigned sig);
    int              p;
    int              sh;
    longint unsigned q;
    longint unsigned rem;
    longint unsigned hlf;
    longint          t;
    p = 63;
    while (p > 0 && sig[p] == 1'b0) p--;
    sh = p - 23;
    if (-149 - ex > sh) sh = -149 - ex;
    if (sh <= 0) begin
      q = sig << (-sh);
    end else if (sh >= 63) begin
      q = 0;
    end else begin
      rem = sig & ((64'd1 << sh) - 1);
      hlf = 64'd1 << (sh - 1);
      q = sig >> sh;
      if (rem > hlf || (rem == hlf && q[0])) q++;
    end
    t = (longint'(ex) + sh + 149) * 8388608 + longint'(q);
    if (t >= 64'sh7F800000) return {sgn, 31'h7F800000};
    return {sgn, t[30:0]};
  endfunction

  function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
    logic            s;
    longint unsigned ma, mb;
    int              ea, eb;
    s = a[31] ^ b[31];
    if (fp_nan(a) || fp_nan(b)) return fimag_pkg::QNAN;
    if (fp_inf(a) || fp_inf(b)) begin
      if (fp_zero(a) || fp_zero(b)) return fimag_pkg::QNAN;
      return {s, 31'h7F800000};
    end
    if (fp_zero(a) || fp_zero(b)) return {s, 31'd0};
    fp_split(a, ma, ea);
    fp_split(b, mb, eb);
    return fp_round(s, ea + eb, ma * mb);
  endfunction

  function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
    logic            sa, sb, ts;
    longint unsigned ma, mb, va, vb, tm, full;
    int              ea, eb, te, d;
    sa = a[31];
    sb = b[31];
    if (fp_nan(a) || fp_nan(b)) return fimag_pkg::QNAN;
    if (fp_inf(a) && fp_inf(b)) return (sa == sb) ? a : fimag_pkg::QNAN;
    if (fp_inf(a)) return a;
    if (fp_inf(b)) return b;
    if (fp_zero(a) && fp_zero(b)) return {sa & sb, 31'd0};
    if (fp_zero(a)) return b;
    if (fp_zero(b)) return a;
    fp_split(a, ma, ea);
    fp_split(b, mb, eb);
    if (eb > ea) begin
      tm = ma; te = ea; ts = sa;
      ma = mb; ea = eb; sa = sb;
      mb = tm; eb = te; sb = ts;
    end
    d = ea - eb;
    va = ma << 30;
    if (d >= 62) begin
      vb = (mb != 0) ? 1 : 0;
    end else begin
      full = mb << 30;
      vb = full >> d;
      if ((vb << d) != full) vb |= 1;
    end
    if (sa == sb) return fp_round(sa, ea - 30, va + vb);
    if (va == vb) return 32'd0;
    if (va > vb) return fp_round(sa, ea - 30, va - vb);
    return fp_round(sb, ea - 30, vb - va);
  endfunction

  function automatic logic [31:0] fp_fix_sub(logic [31:0] t);
    if (fp_nan(t)) return fimag_pkg::QNAN;
    return fp_add(fimag_pkg::ONE_AND_HALF, {~t[31], t[30:0]});
  endfunction

  // squared length, magic guess, two newton refinements
  function automatic logic [31:0] predict_inv_mag(vec_t v);
    logic [31:0] msq, hm, g, t, sub;
    msq = fp_add(fp_mul(v.x, v.x), fp_mul(v.y, v.y));
    hm = fp_mul(msq, fimag_pkg::HALF);
    g = fimag_pkg::MAGIC - {msq[31], msq[31:1]};
    for (int k = 0; k < 2; k++) begin
      t = fp_mul(fp_mul(hm, g), g);
      sub = fp_fix_sub(t);
      g = fp_mul(g, sub);
    end
    return g;
  endfunction

  // random binary32 pattern biased toward interesting exponents
  function automatic logic [31:0] rand_float();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: r[30:23] = 8'd0;
      1: r[30:23] = 8'hFF;
      2: r[30:23] = 8'(128 + $urandom_range(0, 4));
      3: r[30:23] = 8'($urandom_range(1, 8));
      4: r[30:23] = 8'($urandom_range(180, 254));
      5: r[30:0] = 31'd0;
      default: r[30:23] = 8'($urandom_range(100, 154));
    endcase
    return r;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // stimulus: directed vectors first, then random ones
  initial begin
    logic [31:0] edge_vals[12];
    vec_t        v;
    edge_vals = '{32'h00000000, 32'h80000000, 32'h3F800000, 32'hBF800000,
                  32'h7F800000, 32'hFF800000, 32'h7FC00000, 32'hFFFFFFFF,
                  32'h00000001, 32'h007FFFFF, 32'h7F7FFFFF, 32'h5F800000};
    foreach (edge_vals[i]) begin
      v.x = edge_vals[i];
      v.y = edge_vals[(i * 5 + 3) % 12];
      vec_queue.push_back(v);
    end
    vec_queue.push_back('{32'h80000000, 32'h80000000});
    vec_queue.push_back('{32'h7F800000, 32'h00000000});
    vec_queue.push_back('{32'h7F800000, 32'hFF800000});
    vec_queue.push_back('{32'h40400000, 32'h40800000});
    vec_queue.push_back('{32'h00000000, 32'h7F800001});
    vec_queue.push_back('{32'h1F000000, 32'h1F000000});
    for (int i = 0; i < N_RANDOM; i++) begin
      v.x = rand_float();
      v.y = (i % 7 == 0) ? $urandom : rand_float();
      vec_queue.push_back(v);
    end
    feed_done = 1'b1;
  end

  // reset
  initial begin
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    n_fail = 0;
    idle_cycles = 0;
    calm = 1'b0;
    in_wait = 1'b0;
    in_gap = 0;
    out_gap = 0;
    in_valid = 1'b0;
    in_vec_x_bits = 32'd0;
    in_vec_y_bits = 32'd0;
    out_stall = 1'b0;
  end

  // driver: presents the next vector, holds it while stalled
  always @(negedge clk) begin
    calm <= vec_queue.size() < CALM_ITEMS;
    if (rst_n) begin
      if (in_wait) begin
        // hold the beat
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (vec_queue.size() > 0 && (calm || $urandom_range(0, 5) != 0)) begin
        in_valid <= 1'b1;
        in_vec_x_bits <= vec_queue[0].x;
        in_vec_y_bits <= vec_queue[0].y;
        inv_mag_queue.push_back(predict_inv_mag(vec_queue[0]));
        void'(vec_queue.pop_front());
      end else begin
        in_valid <= 1'b0;
        if (!calm && vec_queue.size() > 0) in_gap <= $urandom_range(0, 6);
      end
      // output stall bursts
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 6);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    in_wait <= rst_n && in_valid && in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (inv_mag_queue.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h",
                   $time, out_inv_mag_bits);
          n_fail++;
        end else begin
          if (out_inv_mag_bits !== inv_mag_queue[0]) begin
            $display("%0t: inv_mag_bits mismatch, expected %h, actual %h",
                     $time, inv_mag_queue[0], out_inv_mag_bits);
            n_fail++;
          end
          void'(inv_mag_queue.pop_front());
        end
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // end of run and watchdog
  initial begin
    @(posedge rst_n);
    while (!(feed_done && vec_queue.size() == 0 && !(in_valid && in_stall) &&
             inv_mag_queue.size() == 0) && idle_cycles < IDLE_LIMIT)
      @(posedge clk);
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILED: results differ");
    end else begin
      repeat (fimag_pkg::LATENCY + 10) @(posedge clk);
      if (n_fail == 0) begin
        $display("PASSED: all results match");
      end else begin
        $display("FAILED: results differ");
      end
    end
    $finish;
  end

endmodule
